>>> rtl/sfrp_pkg.sv
package sfrp_pkg;

    // parse phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_OFFSET  = 3'd1;
    localparam logic [2:0] PH_TYPE    = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_LABEL   = 3'd4;
    localparam logic [2:0] PH_SKIP    = 3'd5;
    localparam logic [2:0] PH_SLD_FIX = 3'd6;
    localparam logic [2:0] PH_SLD_LEN = 3'd7;

    // record types
    localparam logic [7:0] TYP_CONST   = 8'h01;
    localparam logic [7:0] TYP_LABEL_A = 8'h02;
    localparam logic [7:0] TYP_LABEL_B = 8'h05;
    localparam logic [7:0] TYP_LABEL_C = 8'h06;
    localparam logic [7:0] TYP_SLD_A   = 8'h80;
    localparam logic [7:0] TYP_SLD_B   = 8'h8A;
    localparam logic [7:0] TYP_SKIP1   = 8'h82;
    localparam logic [7:0] TYP_SKIP2   = 8'h84;
    localparam logic [7:0] TYP_SKIP4   = 8'h86;
    localparam logic [7:0] TYP_SLD_VAR = 8'h88;

    // result kinds
    localparam logic [1:0] KIND_LABEL_BYTE = 2'd0;
    localparam logic [1:0] KIND_EMPTY      = 2'd1;
    localparam logic [1:0] KIND_HDR_ERR    = 2'd2;
    localparam logic [1:0] KIND_TYPE_ERR   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LOCAL_SIGN  = 2'd0;
    localparam logic [1:0] CFG_PROC_LOCALS = 2'd1;
    localparam logic [1:0] CFG_IGN_CONSTS  = 2'd2;

    localparam logic [7:0] LOCAL_SIGN_RST = 8'h40;
    localparam logic [7:0] HDR_LEN        = 8'd8;
    localparam logic [7:0] HDR_CHECKED    = 8'd4;
    localparam logic [7:0] OFS_LEN        = 8'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sym_offset;
        logic [7:0]  sym_type;
        logic [7:0]  label_byte;
        logic        first_byte;
        logic        last_byte;
        logic        is_local;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h4D;
            2'd1:    v = 8'h4E;
            2'd2:    v = 8'h44;
            default: v = 8'h01;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/symbol_file_record_parser_core.sv
// Symbol file record parser.
// Input channel: one file byte per transfer on i_data_byte (i_valid / o_stall).
// Output channel: zero or one result per input byte (o_valid / i_stall): label
// characters with offset and type, empty-label symbols, and error codes.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index
// (0 local sign, 1 process locals, 2 ignore constants); write only when idle.
// Each byte is decoded in the cycle it is accepted; its result goes to the
// output or, under i_stall, the skid register. One byte is taken every cycle
// while o_stall is low: the phase update and result build are a single small
// step on the byte and the state. A two-entry output stage (result register
// plus skid register) lets the parser keep taking bytes while a result waits;
// o_stall rises only once the skid register is occupied, and it is a plain
// register output. Reset clears the parser to the first header byte, drops
// pending results and restores register defaults. After a header or
// unknown-type error the block still accepts bytes but drops them until reset.
module symbol_file_record_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_sym_offset,
    output logic [7:0]  o_sym_type,
    output logic [7:0]  o_label_byte,
    output logic        o_first_byte,
    output logic        o_last_byte,
    output logic        o_is_local
);

    logic [7:0]  r_local_sign;
    logic        r_proc_locals;
    logic        r_ign_consts;

    logic [2:0]  r_phase,  n_phase;
    logic [7:0]  r_cnt,    n_cnt;
    logic [31:0] r_offset, n_offset;
    logic [7:0]  r_type,   n_type;
    logic        r_first,  n_first;
    logic        r_keep,   n_keep;
    logic        r_local,  n_local;
    logic        r_halted, n_halted;

    logic                 w_acc;
    logic                 w_res_valid;
    sfrp_pkg::t_result    w_res;
    logic [7:0]           w_cnt_dec;

    logic                 r_out_valid;
    sfrp_pkg::t_result    r_out;
    logic                 r_skid_valid;
    sfrp_pkg::t_result    r_skid;

    assign w_acc     = i_valid && !r_skid_valid;
    assign w_cnt_dec = r_cnt - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_sign  <= sfrp_pkg::LOCAL_SIGN_RST;
            r_proc_locals <= 1'b1;
            r_ign_consts  <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sfrp_pkg::CFG_LOCAL_SIGN:  r_local_sign  <= i_cfg_data;
                sfrp_pkg::CFG_PROC_LOCALS: r_proc_locals <= i_cfg_data[0];
                sfrp_pkg::CFG_IGN_CONSTS:  r_ign_consts  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_offset    = r_offset;
        n_type      = r_type;
        n_first     = r_first;
        n_keep      = r_keep;
        n_local     = r_local;
        n_halted    = r_halted;
        w_res_valid = 1'b0;
        w_res       = '0;

        if (w_acc && !r_halted) begin
            case (r_phase)
                sfrp_pkg::PH_HEADER: begin
                    if (r_cnt < sfrp_pkg::HDR_CHECKED &&
                        i_data_byte != sfrp_pkg::magic_byte(r_cnt[1:0])) begin
                        n_halted    = 1'b1;
                        w_res_valid = 1'b1;
                        w_res.kind  = sfrp_pkg::KIND_HDR_ERR;
                    end else if (r_cnt + 8'd1 >= sfrp_pkg::HDR_LEN) begin
                        n_cnt   = 8'd0;
                        n_phase = sfrp_pkg::PH_OFFSET;
                    end else begin
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                sfrp_pkg::PH_OFFSET: begin
                    // little-endian: byte lane picked by the count
                    n_offset = ((r_cnt == 8'd0) ? 32'd0 : r_offset) |
                               ({24'd0, i_data_byte} << {r_cnt[1:0], 3'b000});
                    if (r_cnt + 8'd1 >= sfrp_pkg::OFS_LEN) begin
                        n_cnt   = 8'd0;
                        n_phase = sfrp_pkg::PH_TYPE;
                    end else begin
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                sfrp_pkg::PH_TYPE: begin
                    n_type = i_data_byte;
                    n_cnt  = 8'd0;
                    case (i_data_byte)
                        sfrp_pkg::TYP_CONST, sfrp_pkg::TYP_LABEL_A,
                        sfrp_pkg::TYP_LABEL_B, sfrp_pkg::TYP_LABEL_C:
                            n_phase = sfrp_pkg::PH_LEN;
                        sfrp_pkg::TYP_SLD_A, sfrp_pkg::TYP_SLD_B:
                            n_phase = sfrp_pkg::PH_OFFSET;
                        sfrp_pkg::TYP_SKIP1: begin
                            n_cnt   = 8'd1;
                            n_phase = sfrp_pkg::PH_SKIP;
                        end
                        sfrp_pkg::TYP_SKIP2: begin
                            n_cnt   = 8'd2;
                            n_phase = sfrp_pkg::PH_SKIP;
                        end
                        sfrp_pkg::TYP_SKIP4: begin
                            n_cnt   = 8'd4;
                            n_phase = sfrp_pkg::PH_SKIP;
                        end
                        sfrp_pkg::TYP_SLD_VAR: begin
                            n_cnt   = 8'd4;
                            n_phase = sfrp_pkg::PH_SLD_FIX;
                        end
                        default: begin
                            n_halted         = 1'b1;
                            w_res_valid      = 1'b1;
                            w_res.kind       = sfrp_pkg::KIND_TYPE_ERR;
                            w_res.sym_offset = r_offset;
                            w_res.sym_type   = i_data_byte;
                        end
                    endcase
                end
                sfrp_pkg::PH_LEN: begin
                    n_keep = !(r_ign_consts && r_type == sfrp_pkg::TYP_CONST);
                    n_cnt  = i_data_byte;
                    if (i_data_byte == 8'd0) begin
                        // empty label: first character reads as zero
                        n_local = (r_local_sign == 8'd0);
                        if (!r_proc_locals && n_local) begin
                            n_keep = 1'b0;
                        end
                        n_phase          = sfrp_pkg::PH_OFFSET;
                        w_res_valid      = n_keep;
                        w_res.kind       = sfrp_pkg::KIND_EMPTY;
                        w_res.sym_offset = r_offset;
                        w_res.sym_type   = r_type;
                        w_res.first_byte = 1'b1;
                        w_res.last_byte  = 1'b1;
                        w_res.is_local   = n_local;
                    end else begin
                        n_phase = sfrp_pkg::PH_LABEL;
                        n_local = 1'b0;
                        n_first = 1'b1;
                    end
                end
                sfrp_pkg::PH_LABEL: begin
                    n_first = 1'b0;
                    if (r_first) begin
                        n_local = (i_data_byte == r_local_sign);
                        if (!r_proc_locals && n_local) begin
                            n_keep = 1'b0;
                        end
                    end
                    n_cnt = w_cnt_dec;
                    if (w_cnt_dec == 8'd0) begin
                        n_phase = sfrp_pkg::PH_OFFSET;
                    end
                    w_res_valid      = n_keep;
                    w_res.kind       = sfrp_pkg::KIND_LABEL_BYTE;
                    w_res.sym_offset = r_offset;
                    w_res.sym_type   = r_type;
                    w_res.label_byte = i_data_byte;
                    w_res.first_byte = r_first;
                    w_res.last_byte  = (w_cnt_dec == 8'd0);
                    w_res.is_local   = n_local;
                end
                sfrp_pkg::PH_SKIP: begin
                    n_cnt = w_cnt_dec;
                    if (w_cnt_dec == 8'd0) begin
                        n_phase = sfrp_pkg::PH_OFFSET;
                    end
                end
                sfrp_pkg::PH_SLD_FIX: begin
                    n_cnt = w_cnt_dec;
                    if (w_cnt_dec == 8'd0) begin
                        n_phase = sfrp_pkg::PH_SLD_LEN;
                    end
                end
                sfrp_pkg::PH_SLD_LEN: begin
                    n_cnt   = i_data_byte;
                    n_phase = (i_data_byte == 8'd0) ? sfrp_pkg::PH_OFFSET
                                                    : sfrp_pkg::PH_SKIP;
                end
                default: begin
                    n_phase = sfrp_pkg::PH_OFFSET;
                    n_cnt   = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfrp_pkg::PH_HEADER;
            r_cnt    <= 8'd0;
            r_offset <= 32'd0;
            r_type   <= 8'd0;
            r_first  <= 1'b0;
            r_keep   <= 1'b0;
            r_local  <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_offset <= n_offset;
            r_type   <= n_type;
            r_first  <= n_first;
            r_keep   <= n_keep;
            r_local  <= n_local;
            r_halted <= n_halted;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_res_valid) begin
            if (r_out_valid && i_stall) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (r_out_valid && !i_stall) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            if (r_out_valid && i_stall) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end else if (r_out_valid && !i_stall && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_sym_offset = r_out.sym_offset;
    assign o_sym_type   = r_out.sym_type;
    assign o_label_byte = r_out.label_byte;
    assign o_first_byte = r_out.first_byte;
    assign o_last_byte  = r_out.last_byte;
    assign o_is_local   = r_out.is_local;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt state cleared without reset");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_label_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sfrp_pkg::PH_LABEL) |-> (r_cnt != 8'd0))
        else $error("label phase entered with zero count");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && (w_res.kind == sfrp_pkg::KIND_HDR_ERR ||
                         w_res.kind == sfrp_pkg::KIND_TYPE_ERR)) |=> r_halted)
        else $error("error result did not halt the parser");

    a_no_result_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !w_res_valid)
        else $error("result produced while halted");

endmodule
